// ----- rtl/sbu_pkg.sv -----
package sbu_pkg;

    typedef enum logic [2:0] {
        MODE_SPHERE    = 3'd0,
        MODE_BOX       = 3'd1,
        MODE_CYLINDER  = 3'd2,
        MODE_TORUS     = 3'd3,
        MODE_UNION     = 3'd4,
        MODE_INTERSECT = 3'd5,
        MODE_SUBTRACT  = 3'd6,
        MODE_INVALID   = 3'd7
    } t_mode;

    localparam int DIST_W = 32;
    localparam logic signed [DIST_W-1:0] D_MAX = 32'sh7fff_ffff;
    localparam logic signed [DIST_W-1:0] D_MIN = 32'sh8000_0000;

    localparam int T_W    = 31;
    localparam int TSQ_W  = 2 * T_W;
    localparam int K4_W   = 33;
    localparam int BASE_W = 33;
    localparam int CORR_W = 30;

    function automatic int mag_width(input int frac_bits);
        int ptw;
        ptw = 10 + frac_bits;
        return ((ptw > 31) ? ptw : 31) + 1;
    endfunction

    function automatic int latency(input int frac_bits);
        return 2 * mag_width(frac_bits) + 11;
    endfunction

endpackage

// ----- rtl/sbu_isqrt.sv -----
module sbu_isqrt #(
    parameter int RW = 33,
    parameter int PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    input  logic [PW-1:0]   i_pay,
    output logic            o_vld,
    output logic [RW-1:0]   o_root,
    output logic [PW-1:0]   o_pay
);

    localparam int EW = 2 * RW + 1;

    logic          r_vld  [RW];
    logic [EW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [PW-1:0] r_pay  [RW];

    genvar gi;
    for (gi = 0; gi < RW; gi++) begin : g_stage
        localparam int BIT = RW - 1 - gi;
        logic          s_vld;
        logic [EW-1:0] s_rem;
        logic [RW-1:0] s_root;
        logic [PW-1:0] s_pay;
        logic [EW-1:0] n_trial;
        logic          n_take;

        if (gi == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = EW'(i_rad);
            assign s_root = '0;
            assign s_pay  = i_pay;
        end else begin : g_next
            assign s_vld  = r_vld[gi-1];
            assign s_rem  = r_rem[gi-1];
            assign s_root = r_root[gi-1];
            assign s_pay  = r_pay[gi-1];
        end

        assign n_trial = (EW'(s_root) << (BIT + 1)) | (EW'(1) << (2 * BIT));
        assign n_take  = (s_rem >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi] <= 1'b0;
            end else begin
                r_vld[gi] <= s_vld;
            end
            r_rem[gi]  <= n_take ? (s_rem - n_trial) : s_rem;
            r_root[gi] <= n_take ? (s_root | (RW'(1) << BIT)) : s_root;
            r_pay[gi]  <= s_pay;
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_pay  = r_pay[RW-1];

endmodule

// ----- rtl/sbu_div.sv -----
module sbu_div #(
    parameter int NW = 62,
    parameter int DW = 33,
    parameter int QB = 33
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quot
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [CW-1:0] r_rem  [QB];
    logic [DW-1:0] r_den  [QB];
    logic [QB-1:0] r_quot [QB];

    genvar gi;
    for (gi = 0; gi < QB; gi++) begin : g_stage
        localparam int SH = QB - 1 - gi;
        logic [CW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [QB-1:0] s_quot;
        logic [CW-1:0] n_trial;
        logic          n_take;

        if (gi == 0) begin : g_first
            assign s_rem  = CW'(i_num);
            assign s_den  = i_den;
            assign s_quot = '0;
        end else begin : g_next
            assign s_rem  = r_rem[gi-1];
            assign s_den  = r_den[gi-1];
            assign s_quot = r_quot[gi-1];
        end

        assign n_trial = CW'(s_den) << SH;
        assign n_take  = (s_rem >= n_trial);

        always_ff @(posedge i_clk) begin
            r_rem[gi]  <= n_take ? (s_rem - n_trial) : s_rem;
            r_den[gi]  <= s_den;
            r_quot[gi] <= n_take ? (s_quot | (QB'(1) << SH)) : s_quot;
        end
    end

    assign o_quot = r_quot[QB-1];

endmodule

// ----- rtl/sdf_primitive_and_blend_unit.sv -----
// Throughput: one item per cycle while o_busy is low; two square-root pipelines,
// one root bit per stage, with the blend divider running beside the first, set
// the depth. The receiver cannot stall; each result is shown for one cycle
// under o_valid. Reset is synchronous, active low: it clears all valid bits and
// holds o_busy high during reset and until r_run is set after it.
module sdf_primitive_and_blend_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_mode,
    input  logic [9:0]         i_point_x,
    input  logic [9:0]         i_point_y,
    input  logic [9:0]         i_point_z,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic signed [31:0] i_param_a,
    input  logic signed [31:0] i_param_b,
    input  logic signed [31:0] i_param_c,
    input  logic signed [31:0] i_blend_k,
    output logic               o_busy,
    output logic               o_valid,
    output logic signed [31:0] o_distance,
    output logic               o_bad_mode
);

    localparam int PTW  = 10 + FRAC_BITS;
    localparam int MAGW = sbu_pkg::mag_width(FRAC_BITS);
    localparam int DW   = MAGW + 1;
    localparam int QSW  = MAGW + 2;
    localparam int R1W  = MAGW + 1;
    localparam int SW   = MAGW + 2;
    localparam int RDW  = SW + 1;
    localparam int R2W  = SW + 1;
    localparam int FW   = R2W + 3;
    localparam int SQ1W = 2 * MAGW;
    localparam int N1W  = 2 * R1W;
    localparam int SQ2W = 2 * SW;
    localparam int N2W  = 2 * R2W;
    localparam int P1W  = 3 + 32 + 32 + 3 * QSW + MAGW + sbu_pkg::BASE_W + 2;
    localparam int P2W  = 3 + 32 + RDW + 32;

    function automatic logic signed [31:0] sat(input logic signed [FW-1:0] x);
        if (x > FW'(sbu_pkg::D_MAX)) begin
            return sbu_pkg::D_MAX;
        end else if (x < FW'(sbu_pkg::D_MIN)) begin
            return sbu_pkg::D_MIN;
        end
        return x[31:0];
    endfunction

    logic r_run;
    logic n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign o_busy = !r_run;
    assign n_acc  = i_start && r_run;

    // stage A: offsets, magnitudes, box extents, blend setup
    logic [PTW-1:0]             n_px, n_py, n_pz;
    logic signed [DW-1:0]       n_dx, n_dy, n_dz;
    logic [MAGW-1:0]            n_mdx, n_mdy, n_mdz;
    logic signed [QSW-1:0]      n_qx, n_qy, n_qz;
    logic signed [32:0]         n_bb, n_a33, n_base;
    logic signed [33:0]         n_diff;
    logic [33:0]                n_mg;
    logic signed [34:0]         n_tt;
    logic [sbu_pkg::T_W-1:0]    n_tc;
    logic [sbu_pkg::K4_W-1:0]   n_k4;
    logic                       n_take_max, n_smooth;
    logic [P1W-1:0]             n_a_pay;

    assign n_px = {i_point_x, {FRAC_BITS{1'b0}}};
    assign n_py = {i_point_y, {FRAC_BITS{1'b0}}};
    assign n_pz = {i_point_z, {FRAC_BITS{1'b0}}};
    assign n_dx = DW'($signed({1'b0, n_px})) - DW'(i_center_x);
    assign n_dy = DW'($signed({1'b0, n_py})) - DW'(i_center_y);
    assign n_dz = DW'($signed({1'b0, n_pz})) - DW'(i_center_z);
    assign n_mdx = n_dx[DW-1] ? MAGW'(-n_dx) : MAGW'(n_dx);
    assign n_mdy = n_dy[DW-1] ? MAGW'(-n_dy) : MAGW'(n_dy);
    assign n_mdz = n_dz[DW-1] ? MAGW'(-n_dz) : MAGW'(n_dz);
    assign n_qx = QSW'($signed({1'b0, n_mdx})) - QSW'(i_param_a);
    assign n_qy = QSW'($signed({1'b0, n_mdy})) - QSW'(i_param_b);
    assign n_qz = QSW'($signed({1'b0, n_mdz})) - QSW'(i_param_c);

    assign n_bb   = (i_mode == sbu_pkg::MODE_SUBTRACT) ? -33'(i_param_b) : 33'(i_param_b);
    assign n_a33  = 33'(i_param_a);
    assign n_diff = 34'(n_a33) - 34'(n_bb);
    assign n_mg   = n_diff[33] ? 34'(-n_diff) : 34'(n_diff);
    assign n_tt   = 35'(i_blend_k) - $signed({1'b0, n_mg});
    assign n_tc   = n_tt[34] ? '0 : n_tt[sbu_pkg::T_W-1:0];
    assign n_k4   = {i_blend_k[30:0], 2'b00};
    assign n_take_max = (i_mode != sbu_pkg::MODE_UNION);
    assign n_smooth   = (i_blend_k > 32'sd0);
    assign n_base = n_take_max ? ((n_a33 > n_bb) ? n_a33 : n_bb)
                               : ((n_a33 < n_bb) ? n_a33 : n_bb);
    assign n_a_pay = {i_mode, i_param_a, i_param_b, n_qx, n_qy, n_qz, n_mdy,
                      n_base, n_smooth, n_take_max};

    logic                     r_a_vld, r_a_sph;
    logic [MAGW-1:0]          r_a_mdx, r_a_mdy, r_a_mdz;
    logic [sbu_pkg::T_W-1:0]  r_a_tc;
    logic [sbu_pkg::K4_W-1:0] r_a_k4;
    logic [P1W-1:0]           r_a_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= n_acc;
        end
        r_a_sph <= (i_mode == sbu_pkg::MODE_SPHERE);
        r_a_mdx <= n_mdx;
        r_a_mdy <= n_mdy;
        r_a_mdz <= n_mdz;
        r_a_tc  <= n_tc;
        r_a_k4  <= n_k4;
        r_a_pay <= n_a_pay;
    end

    // stage B: squares
    logic                       r_b_vld;
    logic [SQ1W-1:0]            r_b_sx, r_b_sy, r_b_sz;
    logic [sbu_pkg::TSQ_W-1:0]  r_b_tsq;
    logic [sbu_pkg::K4_W-1:0]   r_b_k4;
    logic [P1W-1:0]             r_b_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_sx  <= SQ1W'(r_a_mdx) * SQ1W'(r_a_mdx);
        r_b_sy  <= r_a_sph ? SQ1W'(r_a_mdy) * SQ1W'(r_a_mdy) : '0;
        r_b_sz  <= SQ1W'(r_a_mdz) * SQ1W'(r_a_mdz);
        r_b_tsq <= sbu_pkg::TSQ_W'(r_a_tc) * sbu_pkg::TSQ_W'(r_a_tc);
        r_b_k4  <= r_a_k4;
        r_b_pay <= r_a_pay;
    end

    // stage C: sum of squares
    logic                       r_c_vld;
    logic [N1W-1:0]             r_c_n1;
    logic [sbu_pkg::TSQ_W-1:0]  r_c_tsq;
    logic [sbu_pkg::K4_W-1:0]   r_c_k4;
    logic [P1W-1:0]             r_c_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_n1  <= N1W'(r_b_sx) + N1W'(r_b_sy) + N1W'(r_b_sz);
        r_c_tsq <= r_b_tsq;
        r_c_k4  <= r_b_k4;
        r_c_pay <= r_b_pay;
    end

    logic                   s1_vld;
    logic [R1W-1:0]         s1_root;
    logic [P1W-1:0]         s1_pay;
    logic [R1W-1:0]         dv_quot;

    sbu_isqrt #(.RW(R1W), .PW(P1W)) u_sqrt1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_rad   (r_c_n1),
        .i_pay   (r_c_pay),
        .o_vld   (s1_vld),
        .o_root  (s1_root),
        .o_pay   (s1_pay)
    );

    sbu_div #(.NW(sbu_pkg::TSQ_W), .DW(sbu_pkg::K4_W), .QB(R1W)) u_div (
        .i_clk  (i_clk),
        .i_num  (r_c_tsq),
        .i_den  (r_c_k4),
        .o_quot (dv_quot)
    );

    // stage M1: second-pass operands, inside term, sphere and blend results
    logic [2:0]                   p1_mode;
    logic signed [31:0]           p1_a, p1_b;
    logic signed [QSW-1:0]        p1_qx, p1_qy, p1_qz;
    logic [MAGW-1:0]              p1_mdy;
    logic signed [32:0]           p1_base;
    logic                         p1_smooth, p1_take_max;

    assign {p1_mode, p1_a, p1_b, p1_qx, p1_qy, p1_qz, p1_mdy, p1_base, p1_smooth,
            p1_take_max} = s1_pay;

    logic [sbu_pkg::CORR_W-1:0]   n_corr;
    logic signed [RDW-1:0]        n_radial, n_qy_r, n_cmax;
    logic signed [QSW-1:0]        n_bmax;
    logic signed [FW-1:0]         n_bl, n_sphd;
    logic [SW-1:0]                n_m1_u0, n_m1_u1, n_m1_u2;
    logic signed [RDW-1:0]        n_m1_in;
    logic signed [31:0]           n_m1_early;

    assign n_corr   = dv_quot[sbu_pkg::CORR_W-1:0];
    assign n_radial = RDW'($signed({1'b0, s1_root})) - RDW'(p1_a);
    assign n_qy_r   = RDW'(p1_qy);
    assign n_cmax   = (n_radial > n_qy_r) ? n_radial : n_qy_r;
    assign n_bmax   = (p1_qx > p1_qy) ? ((p1_qx > p1_qz) ? p1_qx : p1_qz)
                                      : ((p1_qy > p1_qz) ? p1_qy : p1_qz);
    assign n_sphd   = FW'($signed({1'b0, s1_root})) - FW'(p1_a);
    assign n_bl = !p1_smooth ? FW'(p1_base)
                : p1_take_max ? FW'(p1_base) + FW'($signed({1'b0, n_corr}))
                              : FW'(p1_base) - FW'($signed({1'b0, n_corr}));

    always_comb begin
        n_m1_u0    = '0;
        n_m1_u1    = '0;
        n_m1_u2    = '0;
        n_m1_in    = '0;
        n_m1_early = '0;
        case (p1_mode)
            sbu_pkg::MODE_SPHERE: begin
                n_m1_early = sat(n_sphd);
            end
            sbu_pkg::MODE_BOX: begin
                n_m1_u0 = p1_qx[QSW-1] ? '0 : SW'(p1_qx);
                n_m1_u1 = p1_qy[QSW-1] ? '0 : SW'(p1_qy);
                n_m1_u2 = p1_qz[QSW-1] ? '0 : SW'(p1_qz);
                n_m1_in = n_bmax[QSW-1] ? RDW'(n_bmax) : '0;
            end
            sbu_pkg::MODE_CYLINDER: begin
                n_m1_u0 = n_radial[RDW-1] ? '0 : n_radial[SW-1:0];
                n_m1_u1 = p1_qy[QSW-1] ? '0 : SW'(p1_qy);
                n_m1_in = n_cmax[RDW-1] ? n_cmax : '0;
            end
            sbu_pkg::MODE_TORUS: begin
                n_m1_u0 = n_radial[RDW-1] ? SW'(-n_radial) : n_radial[SW-1:0];
                n_m1_u1 = SW'(p1_mdy);
            end
            sbu_pkg::MODE_UNION, sbu_pkg::MODE_INTERSECT, sbu_pkg::MODE_SUBTRACT: begin
                n_m1_early = sat(n_bl);
            end
            default: begin
                n_m1_early = '0;
            end
        endcase
    end

    logic           r_m1_vld;
    logic [SW-1:0]  r_m1_u0, r_m1_u1, r_m1_u2;
    logic [P2W-1:0] r_m1_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else begin
            r_m1_vld <= s1_vld;
        end
        r_m1_u0  <= n_m1_u0;
        r_m1_u1  <= n_m1_u1;
        r_m1_u2  <= n_m1_u2;
        r_m1_pay <= {p1_mode, p1_b, n_m1_in, n_m1_early};
    end

    // stage M2: squares
    logic            r_m2_vld;
    logic [SQ2W-1:0] r_m2_s0, r_m2_s1, r_m2_s2;
    logic [P2W-1:0]  r_m2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else begin
            r_m2_vld <= r_m1_vld;
        end
        r_m2_s0  <= SQ2W'(r_m1_u0) * SQ2W'(r_m1_u0);
        r_m2_s1  <= SQ2W'(r_m1_u1) * SQ2W'(r_m1_u1);
        r_m2_s2  <= SQ2W'(r_m1_u2) * SQ2W'(r_m1_u2);
        r_m2_pay <= r_m1_pay;
    end

    // stage M3: sum of squares
    logic           r_m3_vld;
    logic [N2W-1:0] r_m3_n2;
    logic [P2W-1:0] r_m3_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_vld <= 1'b0;
        end else begin
            r_m3_vld <= r_m2_vld;
        end
        r_m3_n2  <= N2W'(r_m2_s0) + N2W'(r_m2_s1) + N2W'(r_m2_s2);
        r_m3_pay <= r_m2_pay;
    end

    logic           s2_vld;
    logic [R2W-1:0] s2_root;
    logic [P2W-1:0] s2_pay;

    sbu_isqrt #(.RW(R2W), .PW(P2W)) u_sqrt2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m3_vld),
        .i_rad   (r_m3_n2),
        .i_pay   (r_m3_pay),
        .o_vld   (s2_vld),
        .o_root  (s2_root),
        .o_pay   (s2_pay)
    );

    // output stage
    logic [2:0]            p2_mode;
    logic signed [31:0]    p2_b;
    logic signed [RDW-1:0] p2_in;
    logic signed [31:0]    p2_early;
    logic signed [FW-1:0]  n_fin_in, n_fin_tor;
    logic signed [31:0]    n_dist;
    logic                  n_bad;

    assign {p2_mode, p2_b, p2_in, p2_early} = s2_pay;
    assign n_fin_in  = FW'($signed({1'b0, s2_root})) + FW'(p2_in);
    assign n_fin_tor = FW'($signed({1'b0, s2_root})) - FW'(p2_b);

    always_comb begin
        n_dist = '0;
        n_bad  = 1'b0;
        case (p2_mode)
            sbu_pkg::MODE_BOX, sbu_pkg::MODE_CYLINDER: begin
                n_dist = sat(n_fin_in);
            end
            sbu_pkg::MODE_TORUS: begin
                n_dist = sat(n_fin_tor);
            end
            sbu_pkg::MODE_SPHERE, sbu_pkg::MODE_UNION, sbu_pkg::MODE_INTERSECT,
            sbu_pkg::MODE_SUBTRACT: begin
                n_dist = p2_early;
            end
            sbu_pkg::MODE_INVALID: begin
                n_bad = 1'b1;
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase
    end

    logic               r_o_vld;
    logic signed [31:0] r_o_dist;
    logic               r_o_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= s2_vld;
        end
        r_o_dist <= n_dist;
        r_o_bad  <= n_bad;
    end

    assign o_valid    = r_o_vld;
    assign o_distance = r_o_dist;
    assign o_bad_mode = r_o_bad;

endmodule

// ----- rtl/sbu_checker.sv -----
module sbu_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic [2:0]         i_mode,
    input logic               o_busy,
    input logic               o_valid,
    input logic signed [31:0] o_distance,
    input logic               o_bad_mode
);

    localparam int LAT = sbu_pkg::latency(FRAC_BITS);

    a_valid_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result without an accepted item");

    a_bad_mode_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bad_mode == $past(i_mode == sbu_pkg::MODE_INVALID, LAT)))
        else $error("bad_mode does not match item mode");

    a_bad_mode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_mode) |-> (o_distance == 32'sd0))
        else $error("nonzero distance on bad mode");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_busy))
        else $error("reset did not clear pipeline");

endmodule

bind sdf_primitive_and_blend_unit sbu_checker #(.FRAC_BITS(FRAC_BITS)) u_sbu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .i_mode     (i_mode),
    .o_busy     (o_busy),
    .o_valid    (o_valid),
    .o_distance (o_distance),
    .o_bad_mode (o_bad_mode)
);

// ----- test/sdf_checker.sv -----
module sdf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_mode,
    input  logic [9:0]         i_point_x,
    input  logic [9:0]         i_point_y,
    input  logic [9:0]         i_point_z,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic signed [31:0] i_param_a,
    input  logic signed [31:0] i_param_b,
    input  logic signed [31:0] i_param_c,
    input  logic signed [31:0] i_blend_k,
    input  logic               i_valid,
    input  logic signed [31:0] i_distance,
    input  logic               i_bad_mode,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [31:0] dval;
        logic               bad;
    } t_outcome;

    t_outcome expected_q[$];

    function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [63:0] root_floor(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] prod;
        r = 0;
        for (int b = 39; b >= 0; b--) begin
            c = r | (64'd1 << b);
            prod = 128'(c) * 128'(c);
            if (prod <= n) r = c;
        end
        return $signed(r);
    endfunction

    function automatic logic [127:0] square(input logic signed [63:0] v);
        logic [63:0] m;
        m = abs64(v);
        return 128'(m) * 128'(m);
    endfunction

    function automatic logic signed [63:0] hyp2(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        return root_floor(square(x) + square(y));
    endfunction

    function automatic logic signed [63:0] hyp3(input logic signed [63:0] x,
                                                 input logic signed [63:0] y,
                                                 input logic signed [63:0] z);
        return root_floor(square(x) + square(y) + square(z));
    endfunction

    function automatic logic signed [63:0] pos(input logic signed [63:0] v);
        return (v > 0) ? v : 0;
    endfunction

    function automatic logic signed [63:0] smooth_pick(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input logic signed [63:0] k,
                                                        input logic want_max);
        logic signed [63:0] base;
        logic signed [63:0] t;
        logic [63:0]        corr;
        base = want_max ? ((a > b) ? a : b) : ((a < b) ? a : b);
        if (k <= 0) return base;
        t = pos(k - abs64(a - b));
        corr = (64'(t) * 64'(t)) / (64'(k) * 64'd4);
        return want_max ? base + $signed(corr) : base - $signed(corr);
    endfunction

    function automatic t_outcome predict_distance();
        logic signed [63:0] dx, dy, dz, a, b, c, k, d, qx, qy, qz, rad, ax;
        t_outcome r;
        dx = (64'(i_point_x) << FRAC) - 64'(i_center_x);
        dy = (64'(i_point_y) << FRAC) - 64'(i_center_y);
        dz = (64'(i_point_z) << FRAC) - 64'(i_center_z);
        a = 64'(i_param_a);
        b = 64'(i_param_b);
        c = 64'(i_param_c);
        k = 64'(i_blend_k);
        d = 0;
        r.bad = 1'b0;
        case (sbu_pkg::t_mode'(i_mode))
            sbu_pkg::MODE_SPHERE: d = hyp3(dx, dy, dz) - a;
            sbu_pkg::MODE_BOX: begin
                qx = abs64(dx) - a;
                qy = abs64(dy) - b;
                qz = abs64(dz) - c;
                ax = (qx > qy) ? qx : qy;
                ax = (ax > qz) ? ax : qz;
                d = hyp3(pos(qx), pos(qy), pos(qz)) + ((ax < 0) ? ax : 0);
            end
            sbu_pkg::MODE_CYLINDER: begin
                rad = hyp2(dx, dz) - a;
                ax = abs64(dy) - b;
                qx = (rad > ax) ? rad : ax;
                d = hyp2(pos(rad), pos(ax)) + ((qx < 0) ? qx : 0);
            end
            sbu_pkg::MODE_TORUS: d = hyp2(hyp2(dx, dz) - a, dy) - b;
            sbu_pkg::MODE_UNION: d = smooth_pick(a, b, k, 1'b0);
            sbu_pkg::MODE_INTERSECT: d = smooth_pick(a, b, k, 1'b1);
            sbu_pkg::MODE_SUBTRACT: d = smooth_pick(a, -b, k, 1'b1);
            default: r.bad = 1'b1;
        endcase
        if (d > 64'(sbu_pkg::D_MAX)) d = 64'(sbu_pkg::D_MAX);
        if (d < 64'(sbu_pkg::D_MIN)) d = 64'(sbu_pkg::D_MIN);
        r.dval = d[31:0];
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_outcome want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result distance=%0d", i_distance);
                    errs = errs + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.dval !== i_distance) begin
                        $error("distance expected %0d actual %0d", want.dval, i_distance);
                        errs = errs + 1;
                    end
                    if (want.bad !== i_bad_mode) begin
                        $error("bad_mode expected %0b actual %0b", want.bad, i_bad_mode);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_start && !i_busy) expected_q.push_back(predict_distance());
        end
    end

endmodule

// ----- test/tb_top.sv -----
module tb_top;

    localparam int WATCHDOG = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic [2:0]         i_mode;
    logic [9:0]         i_point_x, i_point_y, i_point_z;
    logic signed [31:0] i_center_x, i_center_y, i_center_z;
    logic signed [31:0] i_param_a, i_param_b, i_param_c, i_blend_k;
    logic               o_busy, o_valid, o_bad_mode;
    logic signed [31:0] o_distance;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 gap_pct;

    sdf_primitive_and_blend_unit u_dut (.*);

    sdf_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_mode(i_mode), .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_point_z(i_point_z), .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_center_z(i_center_z), .i_param_a(i_param_a), .i_param_b(i_param_b),
        .i_param_c(i_param_c), .i_blend_k(i_blend_k), .i_valid(o_valid),
        .i_distance(o_distance), .i_bad_mode(o_bad_mode),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom_range(0, 32'h00ff_ffff) - 32'h007f_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_centre();
        if ($urandom_range(0, 3) == 0) return pick_word();
        return $urandom_range(0, 32'h03ff_ffff);
    endfunction

    task automatic send_item(input logic [2:0] m, input logic [9:0] px, py, pz,
                             input logic [31:0] cx, cy, cz, pa, pb, pc, bk);
        while ($urandom_range(1, 100) <= gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_mode     <= m;
        i_point_x  <= px;
        i_point_y  <= py;
        i_point_z  <= pz;
        i_center_x <= cx;
        i_center_y <= cy;
        i_center_z <= cz;
        i_param_a  <= pa;
        i_param_b  <= pb;
        i_param_c  <= pc;
        i_blend_k  <= bk;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [2:0]  m;
        logic [31:0] sz;
        m = 3'($urandom_range(0, 7));
        sz = (m < sbu_pkg::MODE_UNION && $urandom_range(0, 3) != 0) ?
             $urandom_range(0, 32'h01ff_ffff) : pick_word();
        send_item(m, 10'($urandom()), 10'($urandom()), 10'($urandom()), pick_centre(),
                  pick_centre(), pick_centre(), sz,
                  ($urandom_range(0, 1) ? sz : pick_word()),
                  pick_word(), ($urandom_range(0, 1) ? pick_word() :
                  $urandom_range(0, 32'h000f_ffff)));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_mode = sbu_pkg::MODE_SPHERE;
        {i_point_x, i_point_y, i_point_z} = '0;
        {i_center_x, i_center_y, i_center_z} = '0;
        {i_param_a, i_param_b, i_param_c, i_blend_k} = '0;
        gap_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(sbu_pkg::MODE_SPHERE, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
        send_item(sbu_pkg::MODE_SPHERE, 10'h3ff, 10'h3ff, 10'h3ff, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_item(sbu_pkg::MODE_SPHERE, 10'h3ff, 0, 10'h3ff, 32'h7fff_ffff, 0, 0,
                  32'h7fff_ffff, 0, 0, 0);
        send_item(sbu_pkg::MODE_BOX, 5, 5, 5, 32'h0005_0000, 32'h0005_0000,
                  32'h0005_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 0);
        send_item(sbu_pkg::MODE_BOX, 10'h3ff, 0, 10'h200, 0, 32'h7fff_ffff,
                  32'h8000_0000, 32'hffff_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_item(sbu_pkg::MODE_CYLINDER, 3, 3, 3, 32'h0003_0000, 32'h0003_0000,
                  32'h0003_0000, 32'h0002_0000, 32'h0004_0000, 0, 0);
        send_item(sbu_pkg::MODE_CYLINDER, 10'h3ff, 10'h3ff, 0, 32'h8000_0000, 0,
                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_item(sbu_pkg::MODE_TORUS, 12, 4, 4, 32'h0004_0000, 32'h0004_0000,
                  32'h0004_0000, 32'h0008_0000, 32'h0001_0000, 0, 0);
        send_item(sbu_pkg::MODE_TORUS, 0, 10'h3ff, 0, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        send_item(sbu_pkg::MODE_UNION, 0, 0, 0, 0, 0, 0, 32'h0001_0000,
                  32'h0002_0000, 0, 0);
        send_item(sbu_pkg::MODE_UNION, 0, 0, 0, 0, 0, 0, 32'h0001_0000,
                  32'h0001_8000, 0, 32'h0001_0000);
        send_item(sbu_pkg::MODE_UNION, 0, 0, 0, 0, 0, 0, 32'h8000_0000,
                  32'h8000_0000, 0, 32'h7fff_ffff);
        send_item(sbu_pkg::MODE_INTERSECT, 0, 0, 0, 0, 0, 0, 32'h0001_0000,
                  32'h0001_0000, 0, 32'h0004_0000);
        send_item(sbu_pkg::MODE_INTERSECT, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff,
                  32'h7fff_ffff, 0, 32'h7fff_ffff);
        send_item(sbu_pkg::MODE_INTERSECT, 0, 0, 0, 0, 0, 0, 32'h0001_0000,
                  32'h0003_0000, 0, 32'h8000_0000);
        send_item(sbu_pkg::MODE_SUBTRACT, 0, 0, 0, 0, 0, 0, 32'h0002_0000,
                  32'h0001_0000, 0, 32'h0002_0000);
        send_item(sbu_pkg::MODE_SUBTRACT, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff,
                  32'h8000_0000, 0, 0);
        send_item(sbu_pkg::MODE_SUBTRACT, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0,
                  32'h7fff_ffff);
        send_item(sbu_pkg::MODE_INVALID, 10'h3ff, 10'h3ff, 10'h3ff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff);

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        gap_pct = 16;
        repeat (360) send_random();
        gap_pct = 78;
        repeat (360) send_random();
        gap_pct = 0;
        repeat (380) send_random();

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (sbu_pkg::latency(16) + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
